// File: sv/assert_macros.svh
// Assertion macros shared by the RPN calculator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a must be followed in the same cycle by condition b.
`define RSC_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("rsc assertion failed");

// Condition a must be followed in the next cycle by condition b.
`define RSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("rsc assertion failed");

`endif

// File: sv/rsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RPN stack calculator.
// Depends on nothing; used by every RTL file of the block.
package rsc_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int DATA_W      = 8;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	// Token kinds carried on the func field.
	typedef enum logic [2:0] {
		FUNC_NUM    = 3'd0,
		FUNC_ADD    = 3'd1,
		FUNC_SUB    = 3'd2,
		FUNC_MUL    = 3'd3,
		FUNC_DIV    = 3'd4,
		FUNC_FINISH = 3'd5
	} func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_FEW      = 3'd2,
		ST_DIVZERO  = 3'd3,
		ST_ENDDEPTH = 3'd4,
		ST_HALTED   = 3'd5
	} status_t;

	// What one stack cell loads in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_SHALLOW,
		CELL_FROM_DEEPER
	} cell_op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIVW,
		S_ZPOP
	} state_t;

	// Request to the divider.
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	// Divider result.
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] quotient;
	} div_res_t;

endpackage

// File: sv/rpn_stack_calculator_8bit.sv
`timescale 1ns / 1ps
// 8-bit RPN stack calculator. A token is accepted in the idle state; the execute
// state then acts on the stack and loads the result register. A divide then waits
// for the bit-serial divider, which yields one quotient bit a cycle; a divide by
// zero drops its divisor in the execute state and its dividend in the state after
// it. Any token waits further while the result register is still full.
// The stack is a row of byte cells that shift toward or away from the top;
// it needs no clearing after reset. One result is returned for every token.
// Depends on rsc_pkg, rsc_cell, rsc_divider and assert_macros.svh.
`include "assert_macros.svh"

module rpn_stack_calculator_8bit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic [7:0] operand_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [7:0] top_value,
	output logic [7:0] depth,
	output logic       final_ready
);
	import rsc_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [2:0]         func_q;
	logic [DATA_W-1:0]  val_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_d;
	logic               halted_q;
	logic               halted_d;
	status_t            err_q;
	status_t            err_d;

	logic               out_valid_q;
	status_t            status_q;
	logic [DATA_W-1:0]  top_q;
	logic [7:0]         depth_out_q;
	logic               final_q;

	logic               out_load;
	status_t            o_status;
	logic [DATA_W-1:0]  o_top;
	logic [DEPTH_W-1:0] o_depth;
	logic               o_final;

	cell_op_t           op_head;
	cell_op_t           op_rest;
	logic [DATA_W-1:0]  load_data;
	logic [DATA_W-1:0]  cell_data [STACK_DEPTH];
	logic [DATA_W-1:0]  c0;
	logic [DATA_W-1:0]  c1;

	div_req_t           div_req;
	div_res_t           div_res;

	logic               go;
	logic               enough;
	logic               full;
	logic               div_path;
	logic [DATA_W-1:0]  tos;
	logic [DATA_W-1:0]  alu_res;
	logic [2*DATA_W-1:0] prod;

	// Stack cells: cell 0 is the top, each takes a neighbor's byte.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] shallow;
		logic [DATA_W-1:0] deeper;
		if (i == 0) begin : g_head
			assign shallow = load_data;
		end else begin : g_body
			assign shallow = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign deeper = '0;
		end else begin : g_inner
			assign deeper = cell_data[i+1];
		end
		rsc_cell u_cell (
			.clk          (clk),
			.op           ((i == 0) ? op_head : op_rest),
			.shallow_data (shallow),
			.deeper_data  (deeper),
			.data         (cell_data[i])
		);
	end

	rsc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// Operand views and simple conditions.
	assign c0       = cell_data[0];
	assign c1       = cell_data[1];
	assign go       = !out_valid_q || out_ready;
	assign enough   = depth_q >= DEPTH_W'(2);
	assign full     = depth_q == DEPTH_W'(STACK_DEPTH);
	assign div_path = !halted_q && (func_q == FUNC_DIV) && enough;
	assign tos      = (depth_q == '0) ? '0 : c0;

	// Arithmetic on the two top entries; the deeper one is the left operand.
	assign prod = c1 * c0;
	always_comb begin
		case (func_q)
			FUNC_ADD: alu_res = c1 + c0;
			FUNC_SUB: alu_res = c1 - c0;
			FUNC_MUL: alu_res = prod[DATA_W-1:0];
			default:  alu_res = '0;
		endcase
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (div_path) begin
					state_d = (c0 == '0) ? S_ZPOP : S_DIVW;
				end else if (go) begin
					state_d = S_IDLE;
				end
			end
			S_DIVW: if (div_res.valid && go) state_d = S_IDLE;
			S_ZPOP: if (go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Stack, error and result control for each state.
	always_comb begin
		op_head          = CELL_HOLD;
		op_rest          = CELL_HOLD;
		load_data        = val_q;
		depth_d          = depth_q;
		halted_d         = halted_q;
		err_d            = err_q;
		div_req.start    = 1'b0;
		div_req.dividend = c1;
		div_req.divisor  = c0;
		out_load         = 1'b0;
		o_status         = ST_OK;
		o_top            = tos;
		o_depth          = depth_q;
		o_final          = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (div_path) begin
					if (c0 == '0) begin
						// Divide by zero: drop the divisor now, the dividend next.
						op_head = CELL_FROM_DEEPER;
						op_rest = CELL_FROM_DEEPER;
						depth_d = depth_q - 1'b1;
					end else begin
						div_req.start = 1'b1;
					end
				end else if (go) begin
					out_load = 1'b1;
					if (func_q == FUNC_FINISH) begin
						o_top   = '0;
						o_depth = '0;
						if (halted_q) begin
							o_status = err_q;
						end else if (depth_q != DEPTH_W'(1)) begin
							o_status = ST_ENDDEPTH;
						end else begin
							o_top   = c0;
							o_final = 1'b1;
						end
						depth_d  = '0;
						halted_d = 1'b0;
						err_d    = ST_OK;
					end else if (halted_q) begin
						o_status = ST_HALTED;
					end else if (func_q == FUNC_NUM) begin
						if (full) begin
							o_status = ST_FULL;
						end else begin
							op_head = CELL_FROM_SHALLOW;
							op_rest = CELL_FROM_SHALLOW;
							depth_d = depth_q + 1'b1;
							o_depth = depth_q + 1'b1;
							o_top   = val_q;
						end
					end else if (func_q inside {FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV}) begin
						if (!enough) begin
							o_status = ST_FEW;
							halted_d = 1'b1;
							err_d    = ST_FEW;
						end else begin
							op_head   = CELL_FROM_SHALLOW;
							op_rest   = CELL_FROM_DEEPER;
							load_data = alu_res;
							depth_d   = depth_q - 1'b1;
							o_depth   = depth_q - 1'b1;
							o_top     = alu_res;
						end
					end
				end
			end
			S_DIVW: begin
				if (div_res.valid && go) begin
					out_load  = 1'b1;
					op_head   = CELL_FROM_SHALLOW;
					op_rest   = CELL_FROM_DEEPER;
					load_data = div_res.quotient;
					depth_d   = depth_q - 1'b1;
					o_depth   = depth_q - 1'b1;
					o_top     = div_res.quotient;
				end
			end
			S_ZPOP: begin
				if (go) begin
					out_load = 1'b1;
					op_head  = CELL_FROM_DEEPER;
					op_rest  = CELL_FROM_DEEPER;
					depth_d  = depth_q - 1'b1;
					halted_d = 1'b1;
					err_d    = ST_DIVZERO;
					o_status = ST_DIVZERO;
					o_depth  = depth_q - 1'b1;
					o_top    = (depth_q == DEPTH_W'(1)) ? '0 : c1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			halted_q    <= 1'b0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			depth_q  <= depth_d;
			halted_q <= halted_d;
			err_q    <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured request and result payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			val_q  <= operand_value;
		end
		if (out_load) begin
			status_q    <= o_status;
			top_q       <= o_top;
			depth_out_q <= 8'(o_depth);
			final_q     <= o_final;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign top_value   = top_q;
	assign depth       = depth_out_q;
	assign final_ready = final_q;

	// Design checks.
	`RSC_ASSERT_NOW(a_depth_bound, clk, arst_n, 1'b1, depth_q <= DEPTH_W'(STACK_DEPTH))
	`RSC_ASSERT_NOW(a_halt_err, clk, arst_n, 1'b1, halted_q == (err_q != ST_OK))
	`RSC_ASSERT_NEXT(a_accept_exec, clk, arst_n, in_valid && in_ready, state_q == S_EXEC)
	`RSC_ASSERT_NOW(a_final_ok, clk, arst_n, out_valid_q && final_q, (status_q == ST_OK) && (depth_out_q == '0))

endmodule

// File: sv/rsc_cell.sv
`timescale 1ns / 1ps
// One byte cell of the shifting stack.
// Depends on rsc_pkg for the data width and the cell operation type.
module rsc_cell (
	input  logic                         clk,
	input  rsc_pkg::cell_op_t            op,
	input  logic [rsc_pkg::DATA_W-1:0]   shallow_data,
	input  logic [rsc_pkg::DATA_W-1:0]   deeper_data,
	output logic [rsc_pkg::DATA_W-1:0]   data
);
	import rsc_pkg::*;

	logic [DATA_W-1:0] data_q;

	// Take the neighbor toward the top on a push, the one below on a pop.
	always_ff @(posedge clk) begin
		case (op)
			CELL_FROM_SHALLOW: data_q <= shallow_data;
			CELL_FROM_DEEPER:  data_q <= deeper_data;
			default:           data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// File: sv/rsc_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider for unsigned bytes, one quotient bit per cycle.
// Depends on rsc_pkg for widths and the request and result structs.
module rsc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  rsc_pkg::div_req_t req,
	output rsc_pkg::div_res_t res
);
	import rsc_pkg::*;

	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 valid_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic                 fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
				busy_q  <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign res.valid    = valid_q;
	assign res.quotient = quo_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8-bit RPN stack calculator.
// Depends on rsc_pkg and rpn_stack_calculator_8bit; predicts every result in place.
module tb_top;
	import rsc_pkg::*;

	// Token codes that the block decodes as no operation.
	localparam logic [2:0] FUNC_SPARE_A = 3'd6;
	localparam logic [2:0] FUNC_SPARE_B = 3'd7;
	localparam int ITEM_TARGET = 1050;
	localparam int DRAIN_CYCLES = 40;

	// One result as the block returns it.
	typedef struct packed {
		status_t    st;
		logic [7:0] top;
		logic [7:0] dep;
		logic       fin;
	} calc_result_t;

	// One directed request; typed rows carry their result, the rest use the predictor.
	typedef struct packed {
		logic [2:0]   f;
		logic [7:0]   v;
		logic         typed;
		calc_result_t want;
	} step_row_t;

	localparam step_row_t DIRECTED_STEPS [26] = '{
		'{FUNC_FINISH,  8'h00, 1'b1, '{ST_ENDDEPTH, 8'h00, 8'h00, 1'b0}},
		'{FUNC_ADD,     8'h00, 1'b1, '{ST_FEW,      8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h5A, 1'b1, '{ST_HALTED,   8'h00, 8'h00, 1'b0}},
		'{FUNC_FINISH,  8'h00, 1'b1, '{ST_FEW,      8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'hFF, 1'b1, '{ST_OK,       8'hFF, 8'h01, 1'b0}},
		'{FUNC_NUM,     8'h01, 1'b1, '{ST_OK,       8'h01, 8'h02, 1'b0}},
		'{FUNC_ADD,     8'h00, 1'b1, '{ST_OK,       8'h00, 8'h01, 1'b0}},
		'{FUNC_NUM,     8'h01, 1'b1, '{ST_OK,       8'h01, 8'h02, 1'b0}},
		'{FUNC_SUB,     8'h00, 1'b1, '{ST_OK,       8'hFF, 8'h01, 1'b0}},
		'{FUNC_NUM,     8'h80, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_MUL,     8'hFF, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h03, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_DIV,     8'h00, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_SPARE_A, 8'hAA, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_SPARE_B, 8'h55, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_FINISH,  8'hFF, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h00, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h00, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_DIV,     8'h00, 1'b1, '{ST_DIVZERO,  8'h00, 8'h00, 1'b0}},
		'{FUNC_FINISH,  8'h00, 1'b1, '{ST_DIVZERO,  8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h09, 1'b1, '{ST_OK,       8'h09, 8'h01, 1'b0}},
		'{FUNC_SUB,     8'h00, 1'b1, '{ST_FEW,      8'h09, 8'h01, 1'b0}},
		'{FUNC_FINISH,  8'h00, 1'b1, '{ST_FEW,      8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h03, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_NUM,     8'h04, 1'b0, '{ST_OK,       8'h00, 8'h00, 1'b0}},
		'{FUNC_FINISH,  8'h00, 1'b1, '{ST_ENDDEPTH, 8'h00, 8'h00, 1'b0}}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] func;
	logic [7:0] operand_value;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] status;
	logic [7:0] top_value;
	logic [7:0] depth;
	logic       final_ready;

	// Predictor copy of the calculator state.
	logic [7:0] calc_stack [STACK_DEPTH];
	int         calc_depth;
	bit         calc_halted;
	status_t    calc_error;

	calc_result_t pending_results [$];
	int fail_count;
	int request_count;
	int effective_count;
	int checked_count;
	int final_count;
	int status_tally [8];
	int sender_calm;

	rpn_stack_calculator_8bit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.top_value     (top_value),
		.depth         (depth),
		.final_ready   (final_ready)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard limit on run time, far above the slowest correct run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Apply one token to the predicted state and return the result it causes.
	function automatic calc_result_t eval_token(input logic [2:0] f, input logic [7:0] v);
		calc_result_t r;
		logic [7:0] lhs;
		logic [7:0] rhs;
		logic [7:0] res;
		r.st = ST_OK;
		r.top = 8'h00;
		r.fin = 1'b0;
		if (f == FUNC_FINISH) begin
			if (calc_halted) begin
				r.st = calc_error;
			end else if (calc_depth != 1) begin
				r.st = ST_ENDDEPTH;
			end else begin
				r.top = calc_stack[0];
				r.fin = 1'b1;
			end
			calc_depth = 0;
			calc_halted = 1'b0;
			calc_error = ST_OK;
		end else begin
			if (calc_halted) begin
				r.st = ST_HALTED;
			end else if (f == FUNC_NUM) begin
				if (calc_depth >= STACK_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					calc_stack[calc_depth] = v;
					calc_depth++;
				end
			end else if (f >= FUNC_ADD && f <= FUNC_DIV) begin
				if (calc_depth < 2) begin
					r.st = ST_FEW;
					calc_halted = 1'b1;
					calc_error = ST_FEW;
				end else begin
					// The deeper operand is the left one; both leave the stack first.
					rhs = calc_stack[calc_depth - 1];
					lhs = calc_stack[calc_depth - 2];
					calc_depth -= 2;
					res = 8'h00;
					case (f)
						FUNC_ADD: res = lhs + rhs;
						FUNC_SUB: res = lhs - rhs;
						FUNC_MUL: res = lhs * rhs;
						default: if (rhs != 8'h00) res = lhs / rhs;
					endcase
					if (f == FUNC_DIV && rhs == 8'h00) begin
						r.st = ST_DIVZERO;
						calc_halted = 1'b1;
						calc_error = ST_DIVZERO;
					end else begin
						calc_stack[calc_depth] = res;
						calc_depth++;
					end
				end
			end
			if (calc_depth > 0) r.top = calc_stack[calc_depth - 1];
		end
		r.dep = 8'(calc_depth);
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sender gaps, with stretches of back-to-back requests.
	function automatic int sender_gap();
		if (sender_calm > 0) begin
			sender_calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) sender_calm = $urandom_range(20, 80);
		return idle_len();
	endfunction

	// Operand values lean toward the extremes.
	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h01;
			3: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [2:0] pick_operator();
		return 3'($urandom_range(FUNC_ADD, FUNC_DIV));
	endfunction

	// Send one request and record its expected result once it is accepted.
	// Called and returning at a falling edge.
	task automatic issue_token(input logic [2:0] f, input logic [7:0] v,
			input bit typed, input calc_result_t typed_result);
		int gap;
		calc_result_t r;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		operand_value = v;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = eval_token(f, v);
		if (typed) r = typed_result;
		pending_results.push_back(r);
		request_count++;
		if (r.st != ST_HALTED && f <= FUNC_FINISH) effective_count++;
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result is back.
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// A well-formed expression with random operands, closed by a finish.
	task automatic run_expression();
		int ops_left;
		bit push;
		ops_left = $urandom_range(1, 10);
		while (!calc_halted && (ops_left > 0 || calc_depth != 1)) begin
			push = calc_depth < 2 || (ops_left > 0 && calc_depth < 8 && $urandom_range(0, 1));
			if (push) begin
				issue_token(FUNC_NUM, pick_operand(), 1'b0, '0);
			end else begin
				issue_token(pick_operator(), 8'($urandom_range(0, 255)), 1'b0, '0);
				if (ops_left > 0) ops_left--;
			end
		end
		issue_token(FUNC_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// Fill the stack past full, fold it back down, then finish.
	task automatic run_deep();
		int keep;
		keep = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
		while (!calc_halted && calc_depth < STACK_DEPTH)
			issue_token(FUNC_NUM, pick_operand(), 1'b0, '0);
		repeat ($urandom_range(1, 3)) issue_token(FUNC_NUM, pick_operand(), 1'b0, '0);
		while (!calc_halted && calc_depth > keep)
			issue_token(pick_operator(), 8'($urandom_range(0, 255)), 1'b0, '0);
		issue_token(FUNC_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// Arbitrary tokens, including spare codes, sometimes left unfinished.
	task automatic run_noise();
		repeat ($urandom_range(1, 8))
			issue_token(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0, '0);
		if ($urandom_range(0, 1))
			issue_token(FUNC_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic check_field(input string label, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
			fail_count++;
		end
	endtask

	// Result receiver: ready in bursts of random length with random stalls.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			out_ready = 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
					: $urandom_range(1, 8)) @(negedge clk);
			repeat (idle_len()) begin
				out_ready = 1'b0;
				@(negedge clk);
			end
		end
	end

	// Compare each returned result with the oldest expectation.
	always @(posedge clk) begin : result_check
		calc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, status %0d top %0d depth %0d final %0b",
					$time, status, top_value, depth, final_ready);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 8'(want.st), 8'(status));
				check_field("top_value", want.top, top_value);
				check_field("depth", want.dep, depth);
				check_field("final_ready", 8'(want.fin), 8'(final_ready));
				checked_count++;
				status_tally[want.st]++;
				if (want.fin) final_count++;
			end
		end
	end

	// Stimulus: reset, directed table, then randomized token streams.
	initial begin : stimulus
		bit first_deep;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_NUM;
		operand_value = 8'h00;
		calc_depth = 0;
		calc_halted = 1'b0;
		calc_error = ST_OK;
		fail_count = 0;
		sender_calm = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < $size(DIRECTED_STEPS); i++)
			issue_token(DIRECTED_STEPS[i].f, DIRECTED_STEPS[i].v,
				DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
		drain_results();

		first_deep = 1'b1;
		while (effective_count < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (first_deep || pick < 4) begin
				run_deep();
				first_deep = 1'b0;
			end else if (pick < 75) begin
				run_expression();
			end else begin
				run_noise();
			end
			if ($urandom_range(0, 29) == 0) drain_results();
		end

		// Let the last results come back, then watch for strays.
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d acting on the stack); checked %0d results, %0d finals.",
			request_count, effective_count, checked_count, final_count);
		$display("Seen: %0d full drops, %0d short stacks, %0d zero divisors, %0d bad end depths.",
			status_tally[ST_FULL], status_tally[ST_FEW], status_tally[ST_DIVZERO],
			status_tally[ST_ENDDEPTH]);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: rpn_stack_calculator_8bit.f
+incdir+sv
sv/rsc_pkg.sv
sv/rsc_cell.sv
sv/rsc_divider.sv
sv/rpn_stack_calculator_8bit.sv
dv/tb_top.sv
